>>> rtl/srf_pkg.sv
package srf_pkg;

  // field and register widths
  localparam int BYTE_W       = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int LEN_W        = 6;
  localparam int BSIZE_W      = 11;
  localparam int WORD_COUNT   = 4;
  localparam int SECRET_BYTES = WORD_COUNT * (CFG_DATA_W / BYTE_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_WORD_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE   = 3'd5;

  // reset values of the registers
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 11'd1024;

  // replacement text
  localparam int REDACT_LEN = 10;
  localparam int REP_W      = $clog2(REDACT_LEN);
  localparam logic [BYTE_W-1:0] REPL_TEXT [REDACT_LEN] = '{
    8'h5B, 8'h52, 8'h45, 8'h44, 8'h41, 8'h43, 8'h54, 8'h45, 8'h44, 8'h5D
  };

  // per-cell control from the sequencer
  typedef struct packed {
    logic load;    // take the incoming byte
    logic shift;   // take the neighbor's byte
    logic in_use;  // cell lies inside the active secret length
  } cell_ctrl_t;

endpackage

>>> rtl/srf_stream_if.sv
// message byte channel
interface srf_in_if import srf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_has_byte;
  logic              in_end;

  modport source (output valid, output in_byte, output in_has_byte, output in_end,
                  input ready);
  modport sink   (input valid, input in_byte, input in_has_byte, input in_end,
                  output ready);
endinterface

// redacted byte channel
interface srf_out_if import srf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_has_byte;
  logic              out_end;

  modport source (output valid, output out_byte, output out_has_byte, output out_end,
                  input ready);
  modport sink   (input valid, input out_byte, input out_has_byte, input out_end,
                  output ready);
endinterface

>>> rtl/srf_cell.sv
module srf_cell import srf_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic [BYTE_W-1:0] secret_i,
  input  logic [BYTE_W-1:0] upper_i,
  output logic [BYTE_W-1:0] cand_o,
  output logic              hit_o
);

  logic [BYTE_W-1:0] byte_q, byte_d;

  // window byte as seen this cycle, with the incoming byte written in
  assign cand_o = ctrl_i.load ? in_byte_i : byte_q;

  // move toward the oldest end on a shift
  assign byte_d = ctrl_i.shift ? upper_i : cand_o;

  // compare against this position of the secret
  assign hit_o = !ctrl_i.in_use || (cand_o == secret_i);

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

>>> rtl/secret_redaction_filter.sv
// Streaming secret redaction filter.
// in_ch carries message bytes (in_byte with in_has_byte) and end markers
// (in_end); out_ch carries the redacted bytes, out_end on the last item of a
// message, and a bare end item when a message produced no byte. Registers
// are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; length and buffer
// size are taken when a message opens.
// A row of SECRET_MAX cells holds the window, oldest byte in cell 0; every
// cell compares its byte to its secret byte, and the row shifts one place
// toward cell 0 each time a byte leaves.
// Throughput: one item per cycle while bytes pass as literals and out_ch
// does not stall. A match emits the replacement bytes (ten, fewer at the
// cap); an item with an end marker flushes the window bytes, then a bare
// item when the message produced no byte; meanwhile the sequencer holds
// in_ch.ready low. A literal result sits in the output register the cycle
// after its transfer.
// Reset clears control and registers; window bytes are not cleared and are
// only read once written. When out_ch stalls the output register holds its
// item and in_ch.ready stays low until it moves.
module secret_redaction_filter import srf_pkg::*; #(
  parameter int SECRET_MAX = 32,
  parameter int BUFFER_MAX = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  srf_in_if.sink                in_ch,
  srf_out_if.source             out_ch
);

  localparam int CNT_W  = $clog2(SECRET_MAX + 1);
  localparam int LEFT_W = $clog2(BUFFER_MAX);

  typedef enum logic [1:0] {S_RUN, S_REPL, S_FLUSH} state_e;

  // configuration registers
  logic [LEN_W-1:0]                     cfg_len_q;
  logic [WORD_COUNT-1:0][CFG_DATA_W-1:0] cfg_word_q;
  logic [BSIZE_W-1:0]                   cfg_bsize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q   <= '0;
      cfg_word_q  <= '0;
      cfg_bsize_q <= BSIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SECRET_LENGTH: cfg_len_q     <= cfg_wdata_i[LEN_W-1:0];
        REG_SECRET_WORD_0: cfg_word_q[0] <= cfg_wdata_i;
        REG_SECRET_WORD_1: cfg_word_q[1] <= cfg_wdata_i;
        REG_SECRET_WORD_2: cfg_word_q[2] <= cfg_wdata_i;
        REG_SECRET_WORD_3: cfg_word_q[3] <= cfg_wdata_i;
        REG_BUFFER_SIZE:   cfg_bsize_q   <= cfg_wdata_i[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // control and output registers
  state_e             state_q, state_d;
  logic               open_q, open_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  logic               any_q, any_d;
  logic               endp_q, endp_d;
  logic [REP_W-1:0]   rep_q, rep_d;
  logic               ov_q, ov_d;
  logic [BYTE_W-1:0]  ob_q, ob_d;
  logic               ohas_q, ohas_d;
  logic               oend_q, oend_d;

  // values a message opens with
  logic [31:0]        len_wide, bsize_wide, cap_wide;
  logic [CNT_W-1:0]   new_len;
  logic [LEFT_W-1:0]  start_left;

  assign len_wide   = 32'(cfg_len_q);
  assign bsize_wide = 32'(cfg_bsize_q);
  assign cap_wide   = (bsize_wide > 32'(BUFFER_MAX)) ? 32'(BUFFER_MAX) : bsize_wide;
  assign new_len    = (len_wide > 32'(SECRET_MAX)) ? CNT_W'(SECRET_MAX) : CNT_W'(len_wide);
  assign start_left = (cap_wide == 32'd0) ? '0 : LEFT_W'(cap_wide - 32'd1);

  // message state as seen by the incoming item
  logic [CNT_W-1:0]   cur_len, cur_count, c1;
  logic [LEFT_W-1:0]  cur_left;
  logic               can_load, in_ready, acc, full, load_en, shift_en, match;

  assign cur_len   = open_q ? len_q : new_len;
  assign cur_count = open_q ? count_q : '0;
  assign cur_left  = open_q ? left_q : start_left;
  assign c1        = cur_count + CNT_W'(1);
  assign can_load  = !ov_q || out_ch.ready;
  assign in_ready  = (state_q == S_RUN) && can_load;
  assign acc       = in_ch.valid && in_ready;
  assign full      = in_ch.in_has_byte && (cur_len != '0) && (c1 == cur_len);
  assign load_en   = acc && in_ch.in_has_byte && (cur_len != '0);

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = ov_q;
  assign out_ch.out_byte     = ob_q;
  assign out_ch.out_has_byte = ohas_q;
  assign out_ch.out_end      = oend_q;

  // row of window cells
  logic [SECRET_BYTES*BYTE_W-1:0] secret_flat;
  logic [BYTE_W-1:0]              cand [SECRET_MAX];
  logic [SECRET_MAX-1:0]          hit;
  cell_ctrl_t                     ctrl [SECRET_MAX];

  assign secret_flat = cfg_word_q;
  assign match       = &hit;

  for (genvar gi = 0; gi < SECRET_MAX; gi++) begin : g_cell
    logic [BYTE_W-1:0] sec_b;
    logic [BYTE_W-1:0] upper_b;

    if (gi < SECRET_BYTES) begin : g_sec
      assign sec_b = secret_flat[gi*BYTE_W +: BYTE_W];
    end else begin : g_zero
      assign sec_b = '0;
    end

    if (gi == SECRET_MAX - 1) begin : g_top
      assign upper_b = '0;
    end else begin : g_mid
      assign upper_b = cand[gi+1];
    end

    assign ctrl[gi].load   = load_en && (cur_count == CNT_W'(gi));
    assign ctrl[gi].shift  = shift_en;
    assign ctrl[gi].in_use = CNT_W'(gi) < cur_len;

    srf_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[gi]),
      .in_byte_i (in_ch.in_byte),
      .secret_i  (sec_b),
      .upper_i   (upper_b),
      .cand_o    (cand[gi]),
      .hit_o     (hit[gi])
    );
  end

  // sequencer: literal pass, replacement bytes, window flush
  logic rep_last, fl_last, lit_end;

  always_comb begin
    state_d  = state_q;
    open_d   = open_q;
    len_d    = len_q;
    count_d  = count_q;
    left_d   = left_q;
    any_d    = any_q;
    endp_d   = endp_q;
    rep_d    = rep_q;
    ov_d     = ov_q && !out_ch.ready;
    ob_d     = ob_q;
    ohas_d   = ohas_q;
    oend_d   = oend_q;
    shift_en = 1'b0;
    rep_last = (rep_q == REP_W'(REDACT_LEN - 1)) || (left_q == LEFT_W'(1));
    fl_last  = (count_q == CNT_W'(1)) || (left_q == LEFT_W'(1));
    lit_end  = in_ch.in_end && ((cur_len == CNT_W'(1)) || (cur_left == LEFT_W'(1)));

    unique case (state_q)
      S_RUN: begin
        if (acc && (in_ch.in_has_byte || in_ch.in_end)) begin
          open_d  = 1'b1;
          len_d   = cur_len;
          count_d = cur_count;
          left_d  = cur_left;
          if (in_ch.in_has_byte && (cur_len == '0)) begin
            // plain copy
            if (cur_left != '0) begin
              ov_d   = 1'b1;
              ob_d   = in_ch.in_byte;
              ohas_d = 1'b1;
              oend_d = in_ch.in_end;
              left_d = cur_left - LEFT_W'(1);
            end
            if (in_ch.in_end) begin
              if (cur_left != '0) begin
                open_d = 1'b0;
              end else begin
                state_d = S_FLUSH;
                any_d   = 1'b0;
              end
            end
          end else if (full && match) begin
            // secret found
            state_d = S_REPL;
            rep_d   = '0;
            endp_d  = in_ch.in_end;
            any_d   = 1'b0;
            count_d = '0;
          end else if (full) begin
            // oldest byte leaves as a literal
            shift_en = 1'b1;
            count_d  = cur_count;
            if (cur_left != '0) begin
              ov_d   = 1'b1;
              ob_d   = cand[0];
              ohas_d = 1'b1;
              oend_d = lit_end;
              left_d = cur_left - LEFT_W'(1);
            end
            if (in_ch.in_end) begin
              if ((cur_left != '0) && lit_end) begin
                open_d  = 1'b0;
                count_d = '0;
              end else begin
                state_d = S_FLUSH;
                any_d   = (cur_left != '0);
              end
            end
          end else if (in_ch.in_has_byte) begin
            // window still filling
            count_d = c1;
            if (in_ch.in_end) begin
              state_d = S_FLUSH;
              any_d   = 1'b0;
            end
          end else begin
            // bare end marker
            state_d = S_FLUSH;
            any_d   = 1'b0;
          end
        end
      end
      S_REPL: begin
        if (can_load) begin
          if (left_q == '0) begin
            if (endp_q && !any_q) begin
              ov_d   = 1'b1;
              ob_d   = '0;
              ohas_d = 1'b0;
              oend_d = 1'b1;
            end
            if (endp_q) begin
              open_d = 1'b0;
            end
            state_d = S_RUN;
          end else begin
            ov_d   = 1'b1;
            ob_d   = REPL_TEXT[rep_q];
            ohas_d = 1'b1;
            oend_d = endp_q && rep_last;
            left_d = left_q - LEFT_W'(1);
            any_d  = 1'b1;
            if (rep_last) begin
              state_d = S_RUN;
              if (endp_q) begin
                open_d = 1'b0;
              end
            end else begin
              rep_d = rep_q + REP_W'(1);
            end
          end
        end
      end
      S_FLUSH: begin
        if (can_load) begin
          if ((left_q == '0) || (count_q == '0)) begin
            if (!any_q) begin
              ov_d   = 1'b1;
              ob_d   = '0;
              ohas_d = 1'b0;
              oend_d = 1'b1;
            end
            open_d  = 1'b0;
            count_d = '0;
            state_d = S_RUN;
          end else begin
            shift_en = 1'b1;
            ov_d     = 1'b1;
            ob_d     = cand[0];
            ohas_d   = 1'b1;
            oend_d   = fl_last;
            count_d  = count_q - CNT_W'(1);
            left_d   = left_q - LEFT_W'(1);
            any_d    = 1'b1;
            if (fl_last) begin
              open_d  = 1'b0;
              count_d = '0;
              state_d = S_RUN;
            end
          end
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      open_q  <= 1'b0;
      len_q   <= '0;
      count_q <= '0;
      left_q  <= LEFT_W'(BUFFER_MAX - 1);
      any_q   <= 1'b0;
      endp_q  <= 1'b0;
      rep_q   <= '0;
      ov_q    <= 1'b0;
      ob_q    <= '0;
      ohas_q  <= 1'b0;
      oend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      len_q   <= len_d;
      count_q <= count_d;
      left_q  <= left_d;
      any_q   <= any_d;
      endp_q  <= endp_d;
      rep_q   <= rep_d;
      ov_q    <= ov_d;
      ob_q    <= ob_d;
      ohas_q  <= ohas_d;
      oend_q  <= oend_d;
    end
  end

endmodule

>>> rtl/srf_checker.sv
module srf_checker import srf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] out_byte_i,
  input logic              out_has_byte_i,
  input logic              out_end_i
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_has_byte_i) && $stable(out_end_i))
    else $error("stalled result changed");

  // no input transfer while the output register is blocked
  a_no_take_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output blocked");

  // an item without a byte is a bare end marker
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_has_byte_i |-> out_end_i && (out_byte_i == '0))
    else $error("byteless item is not a bare end marker");

endmodule

bind secret_redaction_filter srf_checker u_srf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_byte_i     (out_ch.out_byte),
  .out_has_byte_i (out_ch.out_has_byte),
  .out_end_i      (out_ch.out_end)
);

>>> dv/secret_redaction_filter_test.sv
`timescale 1ns / 1ps
module secret_redaction_filter_test;
  import srf_pkg::*;

  localparam int WINDOW_MAX    = 32;
  localparam int SIZE_CAP      = 1024;
  localparam int MASK_LEN      = 10;
  localparam logic [8*MASK_LEN-1:0] MASK_TEXT = "[REDACTED]";
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 50;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              last;
  } out_item_t;

  // predicts the redacted stream and checks it transfer by transfer
  class redaction_checker;
    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] word_reg [WORD_COUNT];
    logic [BSIZE_W-1:0]    size_reg;
    logic [BYTE_W-1:0]     window [WINDOW_MAX];
    int unsigned           fill, room, span, made;
    bit                    open;
    out_item_t             redacted_q [$];
    int unsigned           errors, results_seen;

    function new();
      len_reg  = '0;
      foreach (word_reg[i]) word_reg[i] = '0;
      size_reg = BSIZE_RESET;
      fill = 0;
      room = SIZE_CAP - 1;
      span = 0;
      open = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SECRET_LENGTH: len_reg = data[LEN_W-1:0];
        REG_SECRET_WORD_0: word_reg[0] = data;
        REG_SECRET_WORD_1: word_reg[1] = data;
        REG_SECRET_WORD_2: word_reg[2] = data;
        REG_SECRET_WORD_3: word_reg[3] = data;
        REG_BUFFER_SIZE:   size_reg = data[BSIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // lengths past the window act as the full window
    function int unsigned configured_span();
      return (len_reg > WINDOW_MAX) ? WINDOW_MAX : len_reg;
    endfunction

    function logic [BYTE_W-1:0] secret_at(int unsigned i);
      return word_reg[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // bytes past the cap are dropped
    function void push_byte(logic [BYTE_W-1:0] b);
      out_item_t it;
      if (room == 0) return;
      it.data = b;
      it.has  = 1'b1;
      it.last = 1'b0;
      redacted_q.push_back(it);
      room--;
      made++;
    endfunction

    function void take_message_item(logic [BYTE_W-1:0] b, logic has, logic last);
      int unsigned cap;
      bit          hit;
      out_item_t   bare;
      if (!has && !last) return;
      // a message takes length and buffer size when it opens
      if (!open) begin
        cap  = (size_reg > SIZE_CAP) ? SIZE_CAP : size_reg;
        open = 1;
        fill = 0;
        span = configured_span();
        room = (cap > 0) ? cap - 1 : 0;
      end
      made = 0;
      if (has) begin
        if (span == 0) begin
          push_byte(b);
        end else begin
          if (fill < WINDOW_MAX) begin
            window[fill] = b;
            fill++;
          end
          // full window: replace on a match, else let the oldest byte go
          if (fill >= span) begin
            hit = 1;
            for (int i = 0; i < span; i++)
              if (window[i] != secret_at(i)) hit = 0;
            if (hit) begin
              for (int i = 0; i < MASK_LEN; i++)
                push_byte(MASK_TEXT[8*(MASK_LEN-1-i) +: 8]);
              fill = 0;
            end else begin
              push_byte(window[0]);
              for (int i = 1; i < fill; i++) window[i-1] = window[i];
              fill--;
            end
          end
        end
      end
      // end of message: flush the window, mark the last item
      if (last) begin
        for (int i = 0; i < fill; i++) push_byte(window[i]);
        fill = 0;
        if (made > 0) begin
          redacted_q[redacted_q.size()-1].last = 1'b1;
        end else begin
          bare.data = '0;
          bare.has  = 1'b0;
          bare.last = 1'b1;
          redacted_q.push_back(bare);
        end
        open = 0;
      end
    endfunction

    function void match_output(logic [BYTE_W-1:0] b, logic has, logic last);
      out_item_t want;
      results_seen++;
      if (redacted_q.size() == 0) begin
        $display("%0t: unexpected result byte %02h has_byte %0b end %0b",
                 $time, b, has, last);
        errors++;
        return;
      end
      want = redacted_q.pop_front();
      if (want.data !== b) begin
        $display("%0t: out_byte expected %02h got %02h", $time, want.data, b);
        errors++;
      end
      if (want.has !== has) begin
        $display("%0t: out_has_byte expected %0b got %0b", $time, want.has, has);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: out_end expected %0b got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  srf_in_if  in_ch ();
  srf_out_if out_ch ();

  secret_redaction_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  redaction_checker book = new();
  bit               calm;
  bit               hold_done;
  int unsigned      phase_items;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // idle lengths: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // message bytes biased toward secret bytes and the extremes
  function automatic logic [BYTE_W-1:0] pick_byte(int unsigned span);
    case ($urandom_range(0, 3))
      0:       return (span > 0) ? book.secret_at($urandom_range(0, span - 1)) : 8'h00;
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      book.match_output(out_ch.out_byte, out_ch.out_has_byte, out_ch.out_end);
  end

  // output side: random stalls plus one long hold once traffic is flowing
  initial begin
    int unsigned gap, run;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && book.results_seen >= HOLD_AFTER) begin
        hold_done = 1;
        @(negedge clk_i);
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        out_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      run = $urandom_range(1, 12);
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  // offer one item and wait for its transfer
  task automatic send_item(logic [BYTE_W-1:0] b, logic has, logic last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.in_byte     = b;
    in_ch.in_has_byte = has;
    in_ch.in_end      = last;
    do @(posedge clk_i); while (!in_ch.ready);
    book.take_message_item(b, has, last);
    if (has || last) phase_items++;
  endtask

  // wait until every expected byte is out and the block is quiet
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (book.redacted_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    book.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one message built from whole secrets, partial secrets and noise
  task automatic send_message();
    logic [BYTE_W-1:0] text [$];
    int unsigned       span, kind, n;
    bit                end_on_byte;
    span = book.configured_span();
    repeat ($urandom_range(1, (span > 8) ? 2 : 4)) begin
      kind = $urandom_range(0, 9);
      if (kind < 4 && span > 0) begin
        for (int i = 0; i < span; i++) text.push_back(book.secret_at(i));
      end else if (kind < 6 && span > 0) begin
        n = $urandom_range(0, span - 1);
        for (int i = 0; i < n; i++) text.push_back(book.secret_at(i));
        text.push_back(pick_byte(span));
      end else begin
        repeat ($urandom_range(1, 5)) text.push_back(pick_byte(span));
      end
    end
    if ($urandom_range(0, 9) == 0) text.delete();
    end_on_byte = $urandom_range(0, 1);
    foreach (text[i]) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text[i], 1'b1, end_on_byte && (i == text.size() - 1));
    end
    if (!end_on_byte || text.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic run_phase(int unsigned budget, bit quiet);
    calm = quiet;
    phase_items = 0;
    while (phase_items < budget) send_message();
    settle();
    calm = 1'b0;
  endtask

  // main sequence
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = '0;
    in_ch.in_has_byte = 1'b0;
    in_ch.in_end      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_SECRET_LENGTH;
    cfg_wdata_i       = '0;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // plain copy after reset: zero and all-ones bytes, idle item, bare ends
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h81, 1'b0, 1'b1);
    settle();

    // short secret: match, near miss, flush of a partial window
    program_reg(REG_SECRET_LENGTH, 64'd3);
    program_reg(REG_SECRET_WORD_0, 64'h636261);
    send_item("x", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("d", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b1);
    settle();

    // replacement cut at the cap, then a byte swallowed and a bare end
    program_reg(REG_BUFFER_SIZE, 64'd8);
    send_item("x", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b0);
    send_item("z", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    settle();

    // buffer sizes zero and one leave no room for bytes
    program_reg(REG_BUFFER_SIZE, 64'd0);
    send_item(8'h41, 1'b1, 1'b1);
    settle();
    program_reg(REG_BUFFER_SIZE, 64'd1);
    send_item(8'h42, 1'b1, 1'b1);
    settle();

    // single zero secret byte
    program_reg(REG_SECRET_LENGTH, 64'd1);
    program_reg(REG_SECRET_WORD_0, 64'd0);
    program_reg(REG_BUFFER_SIZE, 64'd1024);
    run_phase(10, 1'b0);

    // full-width secret, oversized buffer, no idling
    program_reg(REG_SECRET_LENGTH, 64'd32);
    program_reg(REG_SECRET_WORD_0, {$urandom, $urandom});
    program_reg(REG_SECRET_WORD_1, {$urandom, $urandom});
    program_reg(REG_SECRET_WORD_2, {$urandom, $urandom});
    program_reg(REG_SECRET_WORD_3, {$urandom, $urandom});
    program_reg(REG_BUFFER_SIZE, 64'd2047);
    run_phase(16, 1'b1);

    // length past the window, small buffer so the cap is hit
    program_reg(REG_SECRET_LENGTH, 64'd63);
    program_reg(REG_SECRET_WORD_3, {$urandom, $urandom});
    program_reg(REG_BUFFER_SIZE, 64'($urandom_range(20, 60)));
    run_phase(16, 1'b0);

    // short secrets, junk in the unused register bits
    program_reg(REG_SECRET_LENGTH,
                ({$urandom, $urandom} & ~64'h3F) | 64'($urandom_range(2, 6)));
    program_reg(REG_SECRET_WORD_0, {$urandom, $urandom});
    program_reg(REG_BUFFER_SIZE, 64'($urandom_range(5, 30)));
    run_phase(16, 1'b0);

    // redaction off again
    program_reg(REG_SECRET_LENGTH, 64'd0);
    program_reg(REG_BUFFER_SIZE, 64'd1024);
    run_phase(10, 1'b0);

    if (book.errors == 0 && book.redacted_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
